// File: sv/rational_arith_unit_defines.svh
// ----------------------------------------------------------------------------
// rational_arith_unit_defines
// Assertion macros for the checker file of the rational unit.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

// assertion that is switched off while reset is high
`define RAU_ASSERT_RST(name, ck, rs, prop) \
  name: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("rau assertion failed");

// assertion that is checked at every edge, reset included
`define RAU_ASSERT_ALWAYS(name, ck, prop) \
  name: assert property (@(posedge ck) prop) \
    else $error("rau assertion failed");

`endif

// File: sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  // fixed field widths of the op code and of the result
  localparam int FUNC_W = 2;
  localparam int NUM_W  = 33;
  localparam int DEN_W  = 31;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ADD = 2'd0,
    FN_SUB = 2'd1,
    FN_MUL = 2'd2,
    FN_DIV = 2'd3
  } func_t;

  // which product the shared multiplier forms
  typedef enum logic [1:0] {
    MS_NUM0,
    MS_NUM1,
    MS_DEN
  } mul_sel_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_NORM,
    ST_GCD,
    ST_DIV,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sum_en;
    logic     norm_en;
    logic     gcd_step;
    logic     div_init;
    logic     div_step;
    logic     out_load;
  } rau_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic err;
    logic num_zero;
    logic gcd_done;
    logic div_last;
    logic out_free;
  } rau_stat_t;

endpackage

// File: sv/rational_arith_unit.sv
// Steps from input item to result item: the multiply steps, cross sum, normalize,
// binary gcd loop, divide loop over PW = 2*OPERAND_WIDTH+1 (at most 64) bits, output.
// A zero denominator or zero divisor goes from the first multiply step to the output, a
// zero numerator from normalize. One item at a time: a new item is taken only after the
// result is loaded and the result side is free; the gcd and divide loops set the rate.
// Reset clears the controller and the output valid, the datapath is not reset.
// ----------------------------------------------------------------------------
// rational_arith_unit
// Adds, subtracts, multiplies or divides two rationals and reduces the
// result to lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
module rational_arith_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // a_num, a_den, b_num, b_den
  input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]      s_tdata,
  // func
  input  logic [FUNC_W-1:0]                         s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // res_num, res_den
  output logic [NUM_W+DEN_W-1:0]                    m_tdata,
  // zero_den_error
  output logic [0:0]                                m_tuser
);

  localparam int W = OPERAND_WIDTH;

  rau_cmd_t  cmd;
  rau_stat_t st;

  logic signed [NUM_W-1:0] res_num;
  logic [DEN_W-1:0]        res_den;
  logic                    zero_den_error;

  // sequencer
  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // arithmetic
  rau_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .func           (s_tuser),
    .a_num          ($signed(s_tdata[W-1:0])),
    .a_den          ($signed(s_tdata[2*W-1:W])),
    .b_num          ($signed(s_tdata[3*W-1:2*W])),
    .b_den          ($signed(s_tdata[4*W-1:3*W])),
    .res_num        (res_num),
    .res_den        (res_den),
    .zero_den_error (zero_den_error),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready)
  );

  // pack the result item
  assign m_tdata = {res_den, res_num};
  assign m_tuser = zero_den_error;

endmodule

// File: sv/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: multiply steps, sum, normalize, gcd loop, divide loop, output.
// ----------------------------------------------------------------------------
module rau_ctrl
  import rau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  rau_stat_t st,
  output rau_cmd_t  cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_MUL0;
      end
      ST_MUL0: begin
        state_next = st.err ? ST_OUT : ST_MUL1;
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_SUM;
      ST_SUM:  state_next = ST_NORM;
      ST_NORM: begin
        state_next = st.num_zero ? ST_OUT : ST_GCD;
      end
      ST_GCD: begin
        if (st.gcd_done) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (st.div_last) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      ST_MUL0: begin
        cmd.mul_en  = !st.err;
        cmd.mul_sel = MS_NUM0;
      end
      ST_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_NUM1;
      end
      ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_DEN;
      end
      ST_SUM:  cmd.sum_en = 1'b1;
      ST_NORM: cmd.norm_en = 1'b1;
      ST_GCD: begin
        cmd.div_init = st.gcd_done;
        cmd.gcd_step = !st.gcd_done;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_OUT:  cmd.out_load = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: sv/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: shared multiplier, cross sum, sign fix, binary gcd, two-lane
// restoring divider and the output register.
// ----------------------------------------------------------------------------
module rau_dp
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rau_cmd_t                        cmd,
  output rau_stat_t                       st,
  input  logic [FUNC_W-1:0]               func,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic signed [OPERAND_WIDTH-1:0] a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic signed [OPERAND_WIDTH-1:0] b_den,
  output logic signed [NUM_W-1:0]         res_num,
  output logic [DEN_W-1:0]                res_den,
  output logic                            zero_den_error,
  output logic                            m_tvalid,
  input  logic                            m_tready
);

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
  localparam int CW = $clog2(PW);

  // operand registers
  func_t                op;
  logic signed [W-1:0]  an, ad, bn, bd;
  logic                 err;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op  <= func_t'(func);
      an  <= a_num;
      ad  <= a_den;
      bn  <= b_num;
      bd  <= b_den;
      err <= (a_den == '0) || (b_den == '0) ||
             ((func_t'(func) == FN_DIV) && (b_num == '0));
    end
  end

  // shared multiplier, one product per step
  logic signed [W-1:0]   mul_a, mul_b;
  logic signed [2*W-1:0] prod;
  logic signed [2*W-1:0] p0, p1, p2;

  always_comb begin
    case (cmd.mul_sel)
      MS_NUM0: begin
        mul_a = an;
        mul_b = (op == FN_MUL) ? bn : bd;
      end
      MS_NUM1: begin
        mul_a = bn;
        mul_b = ad;
      end
      MS_DEN: begin
        mul_a = ad;
        mul_b = (op == FN_DIV) ? bn : bd;
      end
      default: begin
        mul_a = an;
        mul_b = bd;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MS_NUM0: p0 <= prod;
        MS_NUM1: p1 <= prod;
        MS_DEN:  p2 <= prod;
        default: p2 <= prod;
      endcase
    end
  end

  // cross sum, wraps at PW bits
  logic signed [PW-1:0] sum_num, sum_den;

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      case (op)
        FN_ADD:  sum_num <= PW'(p0) + PW'(p1);
        FN_SUB:  sum_num <= PW'(p0) - PW'(p1);
        default: sum_num <= PW'(p0);
      endcase
      sum_den <= PW'(p2);
    end
  end

  // sign fix and magnitudes; the most negative sum stays negative
  logic          num_neg, den_neg, num_min, res_neg_c;
  logic [PW-1:0] nm_c, dm_c;
  logic          res_neg, zero_q;
  logic [PW-1:0] mag_n, mag_d;

  assign num_neg   = sum_num[PW-1];
  assign den_neg   = sum_den[PW-1];
  assign num_min   = (sum_num == {1'b1, {(PW-1){1'b0}}});
  assign res_neg_c = (num_neg ^ den_neg) | num_min;
  assign nm_c      = num_neg ? PW'(-sum_num) : PW'(sum_num);
  assign dm_c      = den_neg ? PW'(-sum_den) : PW'(sum_den);

  always_ff @(posedge clk) begin
    if (cmd.norm_en) begin
      res_neg <= res_neg_c;
      zero_q  <= (sum_num == '0);
      mag_n   <= nm_c;
      mag_d   <= dm_c;
    end
  end

  // binary gcd, one step per cycle
  logic [PW-1:0] gx, gy, gdiff;
  logic [CW-1:0] gk;
  logic          gx_ge;

  assign gx_ge = (gx >= gy);
  assign gdiff = gx_ge ? (gx - gy) : (gy - gx);

  always_ff @(posedge clk) begin
    if (cmd.norm_en) begin
      gx <= nm_c;
      gy <= dm_c;
      gk <= '0;
    end else if (cmd.gcd_step) begin
      if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1;
        gy <= gy >> 1;
        gk <= CW'(gk + 1'b1);
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx_ge) begin
        gx <= gdiff >> 1;
      end else begin
        gy <= gdiff >> 1;
      end
    end
  end

  // two-lane restoring divider sharing the gcd as divisor
  logic [PW-1:0] dq [2];
  logic [PW-1:0] dr [2];
  logic [PW:0]   dt [2];
  logic          dge [2];
  logic [PW-1:0] gval;
  logic [CW-1:0] dcnt;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dt[i]  = {dr[i], dq[i][PW-1]};
      dge[i] = (dt[i] >= {1'b0, gval});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      gval  <= PW'((gx | gy) << gk);
      dq[0] <= mag_n;
      dq[1] <= mag_d;
      dr[0] <= '0;
      dr[1] <= '0;
      dcnt  <= '0;
    end else if (cmd.div_step) begin
      for (int i = 0; i < 2; i++) begin
        dq[i] <= {dq[i][PW-2:0], dge[i]};
        dr[i] <= dge[i] ? PW'(dt[i] - {1'b0, gval}) : PW'(dt[i]);
      end
      dcnt <= CW'(dcnt + 1'b1);
    end
  end

  // signed result from the reduced numerator
  logic signed [PW:0] qn_signed;

  assign qn_signed = res_neg ? -$signed({1'b0, dq[0]}) : $signed({1'b0, dq[0]});

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (err) begin
        res_num        <= '0;
        res_den        <= '0;
        zero_den_error <= 1'b1;
      end else if (zero_q) begin
        res_num        <= '0;
        res_den        <= DEN_W'(1);
        zero_den_error <= 1'b0;
      end else begin
        res_num        <= NUM_W'(qn_signed);
        res_den        <= DEN_W'(dq[1]);
        zero_den_error <= 1'b0;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // status to controller
  assign st.err      = err;
  assign st.num_zero = (sum_num == '0);
  assign st.gcd_done = (gx == '0) || (gy == '0);
  assign st.div_last = (dcnt == CW'(PW - 1));
  assign st.out_free = !m_tvalid || m_tready;

endmodule

// File: sv/rau_chk.sv
// ----------------------------------------------------------------------------
// rau_chk
// Port checker for the rational unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "rational_arith_unit_defines.svh"

module rau_chk
  import rau_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [NUM_W+DEN_W-1:0] m_tdata,
  input logic [0:0]             m_tuser
);

  // a stalled result item holds
  `RAU_ASSERT_RST(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // an error item carries zero numerator and denominator
  `RAU_ASSERT_RST(a_err_zero, clk, rst, m_tvalid && m_tuser[0] |-> m_tdata == '0)

  // a good item has a nonzero denominator
  `RAU_ASSERT_RST(a_den_nz, clk, rst, m_tvalid && !m_tuser[0] |-> m_tdata[NUM_W+DEN_W-1:NUM_W] != '0)

  // no result right after reset
  `RAU_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !m_tvalid)

endmodule

bind rational_arith_unit rau_chk u_rau_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rational_arith_unit. Every item offered on the
// input stream is predicted as it is taken: cross products, sign fix of the
// denominator, reduction by the gcd, error on a zero denominator or divisor.
// Results are checked in order against the predictions. Both stream sides
// idle at random, and the result side also holds off for one long stretch.
// ----------------------------------------------------------------------------
module tb
  import rau_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPW       = 16;
  localparam int IN_W      = ((4*OPW+7)/8)*8;
  localparam int N_RANDOM  = 800;
  localparam int DRAIN_CYC = 150;
  localparam int HOLD_CYC  = 600;
  localparam int QUIET_LO  = 30000;
  localparam int QUIET_HI  = 42000;
  localparam int IDLE_PCT  = 24;
  localparam int MAX_SHOWN = 10;

  // one operand pair and the operation
  typedef struct {
    func_t            op;
    logic [OPW-1:0]   a_num;
    logic [OPW-1:0]   a_den;
    logic [OPW-1:0]   b_num;
    logic [OPW-1:0]   b_den;
  } rat_req_t;

  // one reduced fraction
  typedef struct {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             err;
  } rat_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic [FUNC_W-1:0] s_tuser = FN_ADD;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [NUM_W+DEN_W-1:0] m_tdata;
  logic [0:0]       m_tuser;

  rat_req_t pending_ops[$];
  rat_res_t expected_fracs[$];

  int  n_err      = 0;
  int  n_results  = 0;
  int  cyc        = 0;
  bit  req_taken  = 1'b0;
  logic hold_out  = 1'b0;

  rational_arith_unit #(
    .OPERAND_WIDTH(OPW)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // cross products, positive denominator, lowest terms
  function automatic rat_res_t reduce_fraction(rat_req_t r);
    logic [63:0] an, ad, bn, bd, top, bot, mag, x, y, t;
    rat_res_t    res;
    an = {{(64-OPW){r.a_num[OPW-1]}}, r.a_num};
    ad = {{(64-OPW){r.a_den[OPW-1]}}, r.a_den};
    bn = {{(64-OPW){r.b_num[OPW-1]}}, r.b_num};
    bd = {{(64-OPW){r.b_den[OPW-1]}}, r.b_den};
    res.num = '0;
    res.den = '0;
    res.err = 1'b1;
    if (ad == 0 || bd == 0 || (r.op == FN_DIV && bn == 0)) return res;
    case (r.op)
      FN_ADD: begin
        top = an * bd + bn * ad;
        bot = ad * bd;
      end
      FN_SUB: begin
        top = an * bd - bn * ad;
        bot = ad * bd;
      end
      FN_MUL: begin
        top = an * bn;
        bot = ad * bd;
      end
      default: begin
        top = an * bd;
        bot = ad * bn;
      end
    endcase
    // move the sign to the numerator
    if (bot[63]) begin
      top = 64'd0 - top;
      bot = 64'd0 - bot;
    end
    if (bot == 0) return res;
    mag = top[63] ? 64'd0 - top : top;
    res.err = 1'b0;
    if (mag == 0) begin
      res.num = '0;
      res.den = DEN_W'(1);
      return res;
    end
    // euclid on the magnitudes
    x = mag;
    y = bot;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    mag = mag / x;
    bot = bot / x;
    top = top[63] ? 64'd0 - mag : mag;
    res.num = top[NUM_W-1:0];
    res.den = bot[DEN_W-1:0];
    return res;
  endfunction

  task automatic queue_op(func_t op, logic [OPW-1:0] an, logic [OPW-1:0] ad,
                          logic [OPW-1:0] bn, logic [OPW-1:0] bd);
    rat_req_t r;
    r.op    = op;
    r.a_num = an;
    r.a_den = ad;
    r.b_num = bn;
    r.b_den = bd;
    pending_ops.push_back(r);
  endtask

  // full range, small values that share factors, or an edge value
  function automatic logic [OPW-1:0] pick_operand();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) return OPW'($urandom);
    if (sel < 8) return OPW'($urandom_range(40)) - OPW'(20);
    case ($urandom_range(4))
      0: return {1'b1, {(OPW-1){1'b0}}};
      1: return {1'b0, {(OPW-1){1'b1}}};
      2: return '1;
      3: return OPW'(1);
      default: return '0;
    endcase
  endfunction

  // input side: offer the next item, hold it until taken
  always @(negedge clk) begin : drive_in
    rat_req_t r;
    bit       busy;
    bit       idle;
    busy = s_tvalid && !req_taken;
    req_taken = 1'b0;
    idle = !(cyc >= QUIET_LO && cyc < QUIET_HI) && ($urandom_range(99) < IDLE_PCT);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!busy) begin
      if (pending_ops.size() != 0 && !idle) begin
        r = pending_ops.pop_front();
        s_tdata  <= {r.b_den, r.b_num, r.a_den, r.a_num};
        s_tuser  <= r.op;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output side: random back pressure, none in the quiet window
  always @(negedge clk) begin : drive_out
    bit idle;
    idle = !(cyc >= QUIET_LO && cyc < QUIET_HI) && ($urandom_range(99) < IDLE_PCT);
    m_tready <= !rst && !hold_out && !idle;
  end

  // predict on each taken item, check each returned result
  always @(posedge clk) begin : watch
    rat_req_t r;
    rat_res_t want;
    rat_res_t got;
    cyc++;
    if (!rst && s_tvalid && s_tready) begin
      r.op    = func_t'(s_tuser);
      r.a_num = s_tdata[OPW-1:0];
      r.a_den = s_tdata[2*OPW-1:OPW];
      r.b_num = s_tdata[3*OPW-1:2*OPW];
      r.b_den = s_tdata[4*OPW-1:3*OPW];
      expected_fracs.push_back(reduce_fraction(r));
      req_taken = 1'b1;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.num = m_tdata[NUM_W-1:0];
      got.den = m_tdata[NUM_W+DEN_W-1:NUM_W];
      got.err = m_tuser[0];
      n_results++;
      if (expected_fracs.size() == 0) begin
        if (n_err < MAX_SHOWN)
          $display("tb: unexpected result num=%0h den=%0h err=%0b",
                   got.num, got.den, got.err);
        n_err++;
      end else begin
        want = expected_fracs.pop_front();
        if (got.num !== want.num || got.den !== want.den || got.err !== want.err) begin
          if (n_err < MAX_SHOWN)
            $display("tb: result %0d exp num=%0h den=%0h err=%0b got num=%0h den=%0h err=%0b",
                     n_results, want.num, want.den, want.err,
                     got.num, got.den, got.err);
          n_err++;
        end
      end
    end
  end

  // long hold-off on the result side so the input stalls
  initial begin
    while (n_results < 40) @(posedge clk);
    hold_out <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    hold_out <= 1'b0;
  end

  // run time limit
  initial begin
    #(600000 * 12);
    $display("tb: errors");
    $finish;
  end

  // stimulus and end of run
  initial begin
    // plain cases, zero numerator, sign fixes
    queue_op(FN_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    queue_op(FN_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
    queue_op(FN_MUL, 16'sd3, -16'sd4, 16'sd2, 16'sd3);
    queue_op(FN_DIV, 16'sd3, 16'sd4, -16'sd3, 16'sd8);
    queue_op(FN_DIV, 16'sd6, -16'sd4, -16'sd9, 16'sd2);
    queue_op(FN_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
    queue_op(FN_ADD, 16'sd12, 16'sd18, -16'sd4, 16'sd6);
    queue_op(FN_MUL, 16'sd0, 16'sd5, 16'sd7, 16'sd9);
    queue_op(FN_DIV, 16'sd0, 16'sd5, 16'sd7, 16'sd9);
    // operand extremes
    queue_op(FN_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_op(FN_SUB, 16'h8000, 16'sd1, 16'h7fff, 16'sd1);
    queue_op(FN_MUL, 16'h8000, 16'sd1, 16'h8000, 16'sd1);
    queue_op(FN_DIV, 16'h8000, 16'sd1, 16'h7fff, 16'h8000);
    queue_op(FN_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    queue_op(FN_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    queue_op(FN_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    queue_op(FN_SUB, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    queue_op(FN_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_op(FN_SUB, 16'hffff, 16'h7fff, 16'h8000, 16'hffff);
    // error cases
    queue_op(FN_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1);
    queue_op(FN_SUB, 16'sd1, 16'sd1, 16'sd1, 16'sd0);
    queue_op(FN_DIV, 16'sd5, 16'sd7, 16'sd0, 16'sd3);
    queue_op(FN_MUL, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_op(FN_DIV, 16'h8000, 16'h8000, 16'sd0, 16'sd0);
    // random operations and operands
    repeat (N_RANDOM)
      queue_op(func_t'($urandom_range(3)), pick_operand(), pick_operand(),
               pick_operand(), pick_operand());

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_fracs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (n_err == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
